### design/cal_pkg.sv
// cal_pkg: shared types and codes for the cursor array list
// no dependencies
`timescale 1ns / 1ps

package cal_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 4;
  localparam int ST_W   = 3;
  localparam int OCNT_W = 5;
  localparam int OCUR_W = 4;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 4'd2;
  localparam logic [REQ_W-1:0] REQ_LENGTH = 4'd3;
  localparam logic [REQ_W-1:0] REQ_BACK   = 4'd4;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_START  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_END    = 4'd7;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 4'd8;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 4'd9;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_BOUNDARY = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  // edit applied by every cell in the same cycle
  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_UPDATE,
    EDIT_REMOVE
  } cal_edit_t;

  typedef struct packed {
    cal_edit_t edit;
    logic      load_tap;
    logic      shift_tap;
  } cal_cell_ctrl_t;

endpackage

### design/cal_in_if.sv
// cal_in_if: request channel of the cursor array list
// depends on cal_pkg
`timescale 1ns / 1ps

interface cal_in_if;
  import cal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, req_type, key, new_value, input ready);
  modport sink (input valid, req_type, key, new_value, output ready);
endinterface

### design/cal_out_if.sv
// cal_out_if: result channel of the cursor array list
// depends on cal_pkg
`timescale 1ns / 1ps

interface cal_out_if;
  import cal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_value;
  logic [ST_W-1:0]          status;
  logic [OCNT_W-1:0]        element_count;
  logic [OCUR_W-1:0]        cursor_pos;
  logic                     last;

  modport source (output valid, data_value, status, element_count, cursor_pos, last,
                  input ready);
  modport sink (input valid, data_value, status, element_count, cursor_pos, last,
                output ready);
endinterface

### design/cal_cell.sv
// cal_cell: one list entry with its compare and its neighbor moves
// depends on cal_pkg
`timescale 1ns / 1ps

module cal_cell
  import cal_pkg::*;
(
  input  logic                     clk,
  input  cal_cell_ctrl_t           ctrl,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic                     in_range,
  input  logic                     earlier,
  input  logic                     prev_earlier,
  input  logic                     prev_first,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic signed [DATA_W-1:0] tap_next,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap,
  output logic                     match
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic signed [DATA_W-1:0] tap_r, tap_nxt;

  assign match = in_range && (data_r == key);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.edit)
      EDIT_INSERT: begin
        if (prev_earlier) begin
          data_nxt = prev_data;
        end else if (prev_first) begin
          data_nxt = new_value;
        end
      end
      EDIT_UPDATE: begin
        if (match && !earlier) begin
          data_nxt = new_value;
        end
      end
      EDIT_REMOVE: begin
        if (match || earlier) begin
          data_nxt = next_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_comb begin
    tap_nxt = tap_r;
    if (ctrl.load_tap) begin
      tap_nxt = data_r;
    end else if (ctrl.shift_tap) begin
      tap_nxt = tap_next;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data = data_r;
  assign tap  = tap_r;

endmodule

### design/cursor_array_list_core.sv
// cursor_array_list_core: top level of the cursor array list
// depends on cal_pkg, cal_in_if, cal_out_if and cal_cell
`timescale 1ns / 1ps

// usage
//   in_ch carries one request per transaction (req_type, key, new_value);
//   out_ch carries results (data_value, status, element_count, cursor_pos,
//   last), with last high on the final result of each request
//   the list lives in a row of CAPACITY cells; every cell compares its entry
//   with the key at once, so insert, update, remove, length and cursor moves
//   finish in the accepting cycle and their result sits in the output
//   register in the next cycle
//   read copies the row into a tap chain and shifts it toward cell 0,
//   one entry per cycle, until its cursor entry reaches cell 0 and enters
//   the output register; dump uses the same tap chain and gives one result
//   per cycle, count results, as fast as the receiver takes them
//   a new request is taken while the previous result is being taken;
//   during a read or dump in_ch.ready stays low until the last result has
//   entered the output register
//   when the receiver stalls the output register holds its result and the
//   tap chain does not move once it feeds the output register
//   reset clears count, cursor and the handshake state; entries need no
//   clearing pass since nothing past the count is ever read

module cursor_array_list_core
  import cal_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  cal_in_if.sink    in_ch,
  cal_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CUR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SKIP = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CUR_W-1:0] skip_r, skip_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [ST_W-1:0]          out_status_r, out_status_nxt;
  logic [OCNT_W-1:0]        out_count_r, out_count_nxt;
  logic [OCUR_W-1:0]        out_cursor_r, out_cursor_nxt;
  logic                     out_last_r, out_last_nxt;

  // cell row wiring
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
  logic [CAPACITY-1:0]      match_w;
  logic [CAPACITY-1:0]      earlier_w;
  logic [CAPACITY-1:0]      first_w;
  logic [CAPACITY-1:0]      in_range_w;
  cal_cell_ctrl_t           ctrl;

  logic accept, out_free, found, is_empty, is_full;
  logic emit_single;
  logic [ST_W-1:0]          st;
  logic [CNT_W+OCNT_W-1:0]  count_ext;
  logic [CUR_W+OCUR_W-1:0]  cursor_ext;
  logic [CNT_W-1:0]         cursor_wide;
  logic [CNT_W-1:0]         count_dec;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign found       = |match_w;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == CNT_W'(CAPACITY));
  assign cursor_wide = CNT_W'(cursor_r);
  assign count_dec   = count_r - CNT_W'(1);

  // the row: each cell sees its neighbors' entries and match flags
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_earlier, prev_first;
    logic signed [DATA_W-1:0] prev_data, next_data, tap_next;

    assign in_range_w[i] = CNT_W'(i) < count_r;
    if (i == 0) begin : g_head
      assign earlier_w[i] = 1'b0;
    end else begin : g_body
      assign earlier_w[i] = |match_w[i-1:0];
    end
    assign first_w[i] = match_w[i] && !earlier_w[i];

    if (i == 0) begin : g_left_edge
      // an insert into an empty list lands in cell 0
      assign prev_earlier = 1'b0;
      assign prev_first   = is_empty;
      assign prev_data    = cell_data[i];
    end else begin : g_left
      assign prev_earlier = earlier_w[i-1];
      assign prev_first   = first_w[i-1];
      assign prev_data    = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_right_edge
      assign next_data = cell_data[i];
      assign tap_next  = '0;
    end else begin : g_right
      assign next_data = cell_data[i+1];
      assign tap_next  = cell_tap[i+1];
    end

    cal_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .key          (in_ch.key),
      .new_value    (in_ch.new_value),
      .in_range     (in_range_w[i]),
      .earlier      (earlier_w[i]),
      .prev_earlier (prev_earlier),
      .prev_first   (prev_first),
      .prev_data    (prev_data),
      .next_data    (next_data),
      .tap_next     (tap_next),
      .data         (cell_data[i]),
      .tap          (cell_tap[i]),
      .match        (match_w[i])
    );
  end

  // request decode and sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    rem_nxt        = rem_r;
    skip_nxt       = skip_r;
    ctrl.edit      = EDIT_NONE;
    ctrl.load_tap  = 1'b0;
    ctrl.shift_tap = 1'b0;
    emit_single    = 1'b1;
    st             = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.req_type)
            REQ_INSERT: begin
              if (is_empty) begin
                ctrl.edit  = EDIT_INSERT;
                count_nxt  = CNT_W'(1);
                cursor_nxt = '0;
              end else if (!found) begin
                st = ST_NOTFOUND;
              end else if (is_full) begin
                st = ST_FULL;
              end else begin
                ctrl.edit = EDIT_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_READ: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else begin
                ctrl.load_tap = 1'b1;
                emit_single   = 1'b0;
                rem_nxt       = CNT_W'(1);
                skip_nxt      = cursor_r;
                state_nxt     = (cursor_r == '0) ? S_DUMP : S_SKIP;
              end
            end
            REQ_UPDATE: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else if (!found) begin
                st = ST_NOTFOUND;
              end else begin
                ctrl.edit = EDIT_UPDATE;
              end
            end
            REQ_LENGTH: begin
              st = ST_OK;
            end
            REQ_BACK: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else if (cursor_r != '0) begin
                cursor_nxt = cursor_r - CUR_W'(1);
              end else begin
                st = ST_BOUNDARY;
              end
            end
            REQ_NEXT: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else if (cursor_wide + CNT_W'(1) < count_r) begin
                cursor_nxt = cursor_r + CUR_W'(1);
              end else begin
                st = ST_BOUNDARY;
              end
            end
            REQ_START: begin
              cursor_nxt = '0;
            end
            REQ_END: begin
              if (is_empty) begin
                cursor_nxt = '0;
                st         = ST_EMPTY;
              end else begin
                cursor_nxt = CUR_W'(count_dec);
              end
            end
            REQ_REMOVE: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else if (!found) begin
                st = ST_NOTFOUND;
              end else begin
                ctrl.edit = EDIT_REMOVE;
                count_nxt = count_dec;
                // keep the cursor inside the shrunken list
                if (count_dec == '0) begin
                  cursor_nxt = '0;
                end else if (cursor_wide >= count_dec) begin
                  cursor_nxt = CUR_W'(count_dec - CNT_W'(1));
                end
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                st = ST_EMPTY;
              end else begin
                ctrl.load_tap = 1'b1;
                emit_single   = 1'b0;
                rem_nxt       = count_r;
                state_nxt     = S_DUMP;
              end
            end
            default: st = ST_NOTFOUND;
          endcase
        end
      end
      S_SKIP: begin
        // walk the tap chain up to the cursor entry
        ctrl.shift_tap = 1'b1;
        skip_nxt       = skip_r - CUR_W'(1);
        if (skip_r == CUR_W'(1)) begin
          state_nxt = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.shift_tap = 1'b1;
          rem_nxt        = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign count_ext  = (CNT_W + OCNT_W)'(count_nxt);
  assign cursor_ext = (CUR_W + OCUR_W)'(cursor_nxt);

  // output register load
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_cursor_nxt = out_cursor_r;
    out_last_nxt   = out_last_r;
    if (accept && emit_single) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = st;
      out_count_nxt  = count_ext[OCNT_W-1:0];
      out_cursor_nxt = cursor_ext[OCUR_W-1:0];
      out_last_nxt   = 1'b1;
    end else if (state_r == S_DUMP && out_free) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = cell_tap[0];
      out_status_nxt = ST_OK;
      out_count_nxt  = count_ext[OCNT_W-1:0];
      out_cursor_nxt = cursor_ext[OCUR_W-1:0];
      out_last_nxt   = (rem_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      rem_r       <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      rem_r       <= rem_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_value    = out_data_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.cursor_pos    = out_cursor_r;
  assign out_ch.last          = out_last_r;

endmodule

### test/cursor_array_list_core_tb.sv
// cursor_array_list_core_tb: self-checking testbench for the cursor array list
// depends on cal_pkg, cal_in_if, cal_out_if and cursor_array_list_core
`timescale 1ns / 1ps

module cursor_array_list_core_tb
  import cal_pkg::*;
;

  localparam int CAP = 16;
  localparam int RANDOM_ITEMS = 76;
  // request codes past the dump are undefined and answer not found
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_DUMP + 4'd1;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'hF;

  // one result transaction, as seen on the output channel
  typedef struct packed {
    logic [DATA_W-1:0] data_value;
    logic [ST_W-1:0]   status;
    logic [OCNT_W-1:0] element_count;
    logic [OCUR_W-1:0] cursor_pos;
    logic              last;
  } list_result_t;

  // shadow of the list plus the results still owed by the block
  class list_scoreboard;
    logic [DATA_W-1:0] entries[CAP];
    int unsigned       list_len;
    int unsigned       cur;
    list_result_t      awaited_results[$];
    int                errors;

    function new();
      list_len = 0;
      cur = 0;
      errors = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function int unsigned find_first(logic [DATA_W-1:0] v);
      for (int unsigned i = 0; i < list_len; i++) begin
        if (entries[i] == v) return i;
      end
      return list_len;
    endfunction

    function void owe(logic [DATA_W-1:0] data, logic [ST_W-1:0] st, logic lst);
      list_result_t r;
      r.data_value    = data;
      r.status        = st;
      r.element_count = list_len[OCNT_W-1:0];
      r.cursor_pos    = cur[OCUR_W-1:0];
      r.last          = lst;
      awaited_results.push_back(r);
    endfunction

    // apply one accepted request to the shadow list and queue its results
    function void note_request(logic [REQ_W-1:0] op, logic [DATA_W-1:0] key,
                               logic [DATA_W-1:0] nv);
      logic [ST_W-1:0]   st;
      logic [DATA_W-1:0] data;
      int unsigned       hit;
      st = ST_OK;
      data = '0;
      case (op) inside
        REQ_INSERT: begin
          if (list_len == 0) begin
            entries[0] = nv;
            list_len = 1;
            cur = 0;
          end else begin
            hit = find_first(key);
            if (hit >= list_len) st = ST_NOTFOUND;
            else if (list_len >= CAP) st = ST_FULL;
            else begin
              for (int unsigned i = list_len; i > hit + 1; i--) entries[i] = entries[i-1];
              entries[hit+1] = nv;
              list_len++;
            end
          end
        end
        REQ_READ: begin
          if (list_len == 0) st = ST_EMPTY;
          else if (cur >= list_len) st = ST_BOUNDARY;
          else data = entries[cur];
        end
        REQ_UPDATE, REQ_REMOVE: begin
          if (list_len == 0) st = ST_EMPTY;
          else begin
            hit = find_first(key);
            if (hit >= list_len) st = ST_NOTFOUND;
            else if (op == REQ_UPDATE) entries[hit] = nv;
            else begin
              for (int unsigned i = hit; i + 1 < list_len; i++) entries[i] = entries[i+1];
              list_len--;
              // removal never moves the cursor except to keep it in range
              if (list_len == 0) cur = 0;
              else if (cur >= list_len) cur = list_len - 1;
            end
          end
        end
        REQ_LENGTH: ;
        REQ_BACK: begin
          if (list_len == 0) st = ST_EMPTY;
          else if (cur > 0) cur--;
          else st = ST_BOUNDARY;
        end
        REQ_NEXT: begin
          if (list_len == 0) st = ST_EMPTY;
          else if (cur + 1 < list_len) cur++;
          else st = ST_BOUNDARY;
        end
        REQ_START: cur = 0;
        REQ_END: begin
          if (list_len == 0) begin
            cur = 0;
            st = ST_EMPTY;
          end else cur = list_len - 1;
        end
        REQ_DUMP: begin
          if (list_len == 0) owe('0, ST_EMPTY, 1'b1);
          else begin
            for (int unsigned i = 0; i < list_len; i++) begin
              owe(entries[i], ST_OK, i + 1 == list_len);
            end
          end
          return;
        end
        default: st = ST_NOTFOUND;
      endcase
      owe(data, st, 1'b1);
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = awaited_results.pop_front();
      check_field("data_value", exp_r.data_value, got.data_value);
      check_field("status", DATA_W'(exp_r.status), DATA_W'(got.status));
      check_field("element_count", DATA_W'(exp_r.element_count),
                  DATA_W'(got.element_count));
      check_field("cursor_pos", DATA_W'(exp_r.cursor_pos), DATA_W'(got.cursor_pos));
      check_field("last", DATA_W'(exp_r.last), DATA_W'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  // when set, neither side idles or stalls
  logic steady;

  cal_in_if  in_ch ();
  cal_out_if out_ch ();

  cursor_array_list_core #(.CAPACITY(CAP)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: stalls about one cycle in six, except during steady stretches
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 16);
    end
  end

  // every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.data_value, out_ch.status, out_ch.element_count,
                       out_ch.cursor_pos, out_ch.last});
    end
  end

  // drive one request and hold it until the block takes the transaction;
  // the prediction is made right at acceptance so the next pick sees it
  task automatic send_request(input logic [REQ_W-1:0] op, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] nv);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= op;
    in_ch.key       <= key;
    in_ch.new_value <= nv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, key, nv);
  endtask

  // values come from a small pool often, so duplicates and first-match
  // behavior show up, plus the extremes and full-range noise
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 7);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  // keys mostly hit a stored entry so edits get past the search
  function automatic logic [DATA_W-1:0] pick_key();
    if (sb.list_len != 0 && $urandom_range(0, 99) < 75)
      return sb.entries[$urandom_range(0, sb.list_len - 1)];
    return pick_value();
  endfunction

  // request mix: ins_pct inserts, rem_pct removes, the rest spread over the
  // other operations, with a few undefined codes as noise
  function automatic logic [REQ_W-1:0] pick_op(int unsigned ins_pct, int unsigned rem_pct);
    logic [REQ_W-1:0] others[8];
    int unsigned r;
    others = '{REQ_READ, REQ_UPDATE, REQ_LENGTH, REQ_BACK,
               REQ_NEXT, REQ_START, REQ_END, REQ_DUMP};
    r = $urandom_range(0, 99);
    if (r < ins_pct) return REQ_INSERT;
    if (r < ins_pct + rem_pct) return REQ_REMOVE;
    if (r < 95) return others[$urandom_range(0, 7)];
    return REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
  endfunction

  initial begin
    rst_n = 1'b0;
    steady = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LENGTH;
    in_ch.key = '0;
    in_ch.new_value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every request but insert on an empty list
    send_request(REQ_READ, 0, 0);
    send_request(REQ_DUMP, 0, 0);
    send_request(REQ_BACK, 0, 0);
    send_request(REQ_NEXT, 0, 0);
    send_request(REQ_END, 0, 0);
    send_request(REQ_UPDATE, 0, 1);
    send_request(REQ_REMOVE, 0, 0);
    send_request(REQ_LENGTH, 0, 0);
    send_request(REQ_START, 0, 0);
    // first value goes in regardless of key, then key misses and hits
    send_request(REQ_INSERT, 32'h1234_5678, 32'h8000_0000);
    send_request(REQ_INSERT, 32'h0000_0005, 32'h0000_0009);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h8000_0000, 32'h8000_0000);
    // cursor walls and a read at the tail
    send_request(REQ_BACK, 0, 0);
    send_request(REQ_END, 0, 0);
    send_request(REQ_NEXT, 0, 0);
    send_request(REQ_READ, 0, 0);
    // removing the tail pulls the cursor back into range
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 0);
    // duplicate key: only the first match is rewritten
    send_request(REQ_UPDATE, 32'h8000_0000, 32'h5555_5555);
    send_request(REQ_READ, 0, 0);
    send_request(REQ_DUMP, 0, 0);
    send_request(REQ_UNUSED_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'h0BAD_0BAD, 0);
    send_request(REQ_UPDATE, 32'h0BAD_0BAD, 32'h1);

    // random part in four stretches: grow toward full, steady mix, shrink
    // toward empty, then a final mix
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      int unsigned block;
      logic [REQ_W-1:0] op;
      block = i / (RANDOM_ITEMS / 4);
      steady <= (block == 1);
      case (block)
        0: op = pick_op(85, 5);
        2: op = pick_op(5, 60);
        default: op = pick_op(30, 15);
      endcase
      send_request(op, pick_key(), pick_value());
    end

    // drain: wait for every owed result, then a little longer to catch extras
    in_ch.valid <= 1'b0;
    steady <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    @(negedge clk);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard limit well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
design/cal_pkg.sv
design/cal_in_if.sv
design/cal_out_if.sv
design/cal_cell.sv
design/cursor_array_list_core.sv
test/cursor_array_list_core_tb.sv
